@@ hdl/sap_pkg.sv @@
// ----------------------------------------------------------------------------
// sap_pkg
// Types, codes and small helpers shared by the shelf atlas packer.
// ----------------------------------------------------------------------------
package sap_pkg;

  // Coordinate width of every stored row value and every size field
  localparam int unsigned COORD_BITS = 13;
  localparam int unsigned POS_BITS   = 12;
  localparam int unsigned STAT_BITS  = 3;
  localparam int unsigned IDX_BITS   = 2;
  localparam int unsigned USED_BITS  = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  // Largest atlas dimension; register values above it are clamped
  localparam logic [COORD_BITS-1:0] DIM_CAP = COORD_BITS'(4096);

  // Command codes
  localparam logic CMD_PLACE     = 1'b0;
  localparam logic CMD_NEW_BATCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_PLACED    = STAT_BITS'(0);
  localparam logic [STAT_BITS-1:0] ST_SHARED    = STAT_BITS'(1);
  localparam logic [STAT_BITS-1:0] ST_TOO_LARGE = STAT_BITS'(2);
  localparam logic [STAT_BITS-1:0] ST_NO_ROOM   = STAT_BITS'(3);
  localparam logic [STAT_BITS-1:0] ST_CLEARED   = STAT_BITS'(4);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Request transaction
  typedef struct packed {
    logic   command;
    coord_t rect_width;
    coord_t rect_height;
    logic   is_shared;
  } sap_req_t;

  // Result transaction
  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [IDX_BITS-1:0]  atlas_index;
    logic [POS_BITS-1:0]  pos_x;
    logic [POS_BITS-1:0]  pos_y;
    logic [USED_BITS-1:0] atlases_used;
  } sap_res_t;

  // One row (shelf) entry of the row table
  typedef struct packed {
    coord_t top;
    coord_t left;
    coord_t tall;
  } sap_row_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } sap_state_e;

  // Kind of token moving from the read-issue stage to the check stage
  typedef enum logic [1:0] {
    TK_NONE,
    TK_ROW,
    TK_END,
    TK_DONE
  } sap_tok_e;

  function automatic coord_t cap_dim(input coord_t v);
    return (v > DIM_CAP) ? DIM_CAP : v;
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    return (a > b) ? coord_t'(a - b) : '0;
  endfunction

endpackage

@@ hdl/shelf_atlas_packer.sv @@
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// First-fit shelf packing of rectangles into a set of equal-size atlases.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low; exactly one
// result follows, shown for one cycle with done_o high, and the receiver
// cannot hold it off. New-batch, shared and oversize requests answer in the
// cycle after they are taken. A placement walks the row table in one RAM,
// one row per cycle, atlas after atlas, with an end step for each open atlas
// and a final step for the new-atlas decision. The registered RAM read is
// hidden by issuing the next row read while the previous row is checked. The
// row table needs no clearing pass: only rows counted as opened in the current
// batch are read.
// ----------------------------------------------------------------------------
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int unsigned MAX_ATLASES = 4,
  parameter int unsigned MAX_ROWS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sap_req_t             req_i,
  output logic                 done_o,
  output sap_res_t             result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  coord_t               cfg_wdata_i
);

  localparam int unsigned SLOTS = MAX_ATLASES * MAX_ROWS;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned AW    = $clog2(MAX_ATLASES + 1);
  localparam int unsigned AIW   = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);

  // Configuration registers
  coord_t atlas_w_q, atlas_h_q;
  coord_t aw, ah;

  // Per-atlas state
  logic [RW-1:0] rows_q [MAX_ATLASES];
  logic [RW-1:0] rows_d [MAX_ATLASES];
  coord_t        hl_q   [MAX_ATLASES];
  coord_t        hl_d   [MAX_ATLASES];
  logic [AW-1:0] total_q, total_d;

  // Controller and item registers
  sap_state_e    state_q, state_d;
  coord_t        w_q, h_q;

  // Read-issue stage
  logic          run_q, run_d;
  logic [AW-1:0] ia_q, ia_d;
  logic [RW-1:0] ir_q, ir_d;
  logic [SW-1:0] raddr;
  sap_tok_e      tok_kind;

  // Check stage
  sap_tok_e      ck_kind_q, ck_kind_d;
  logic [AW-1:0] ck_atlas_q;
  logic [SW-1:0] ck_slot_q;

  // RAM ports
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  sap_row_t      ram_wdata, ram_rdata;

  // Result register
  logic          done_q, done_d;
  sap_res_t      res_q, res_d;

  // Decision signals
  logic          accept, finish, row_hit, end_fit, open_row, no_room;
  logic [AW-1:0] open_atlas;
  logic [RW-1:0] open_rows;
  coord_t        open_hl, open_top;
  logic [AW-1:0] ia_rd_sel;

  function automatic logic [SW-1:0] slot_of(input logic [AW-1:0] a, input logic [RW-1:0] r);
    return SW'(int'(a) * MAX_ROWS + int'(r));
  endfunction

  assign aw     = cap_dim(atlas_w_q);
  assign ah     = cap_dim(atlas_h_q);
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  // Row table
  sap_ram #(
    .WIDTH($bits(sap_row_t)),
    .DEPTH(SLOTS)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= COORD_BITS'(2048);
      atlas_h_q <= COORD_BITS'(2048);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATLAS_WIDTH:  atlas_w_q <= cfg_wdata_i;
        CFG_ATLAS_HEIGHT: atlas_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Issue stage: produce the next token and row read address
  always_comb begin
    ia_rd_sel = ia_q;
    tok_kind  = TK_NONE;
    raddr     = slot_of(ia_q, ir_q);
    ia_d      = ia_q;
    ir_d      = ir_q;
    run_d     = run_q;
    if (state_q == S_SCAN && run_q) begin
      if (ia_q == total_q) begin
        tok_kind = TK_DONE;
        run_d    = 1'b0;
      end else if (ir_q < rows_q[ia_rd_sel[AIW-1:0]]) begin
        tok_kind = TK_ROW;
        ir_d     = RW'(ir_q + 1'b1);
      end else begin
        tok_kind = TK_END;
        ia_d     = AW'(ia_q + 1'b1);
        ir_d     = '0;
      end
    end
    if (accept) begin
      ia_d  = '0;
      ir_d  = '0;
      run_d = (req_i.command == CMD_PLACE) && !req_i.is_shared &&
              !(req_i.rect_width > aw || req_i.rect_height > ah);
    end
    ck_kind_d = tok_kind;
  end

  // Check stage: decide on the current token
  always_comb begin
    row_hit    = (ck_kind_q == TK_ROW) &&
                 (w_q <= sat_sub(aw, ram_rdata.left)) && (h_q <= ram_rdata.tall);
    end_fit    = (ck_kind_q == TK_END) &&
                 (h_q <= hl_q[ck_atlas_q[AIW-1:0]]) &&
                 (rows_q[ck_atlas_q[AIW-1:0]] < RW'(MAX_ROWS));
    no_room    = (ck_kind_q == TK_DONE) && (total_q == AW'(MAX_ATLASES));
    open_row   = end_fit || ((ck_kind_q == TK_DONE) && !no_room);
    finish     = (state_q == S_SCAN) && (row_hit || open_row || no_room);
    // A new atlas behaves as an atlas with full height and no rows
    if (ck_kind_q == TK_DONE) begin
      open_atlas = total_q;
      open_rows  = '0;
      open_hl    = ah;
    end else begin
      open_atlas = ck_atlas_q;
      open_rows  = rows_q[ck_atlas_q[AIW-1:0]];
      open_hl    = hl_q[ck_atlas_q[AIW-1:0]];
    end
    open_top = sat_sub(ah, open_hl);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && run_d) state_d = S_SCAN;
      S_SCAN: if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Writes, per-atlas updates and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ck_slot_q;
    ram_wdata = ram_rdata;
    rows_d    = rows_q;
    hl_d      = hl_q;
    total_d   = total_q;
    done_d    = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.atlas_index  = '0;
          res_d.pos_x        = '0;
          res_d.pos_y        = '0;
          res_d.atlases_used = USED_BITS'(total_q);
          if (req_i.command == CMD_NEW_BATCH) begin
            // Drop every atlas; row entries are never read before reopening
            for (int i = 0; i < MAX_ATLASES; i++) rows_d[i] = '0;
            total_d            = '0;
            res_d.status       = ST_CLEARED;
            res_d.atlases_used = '0;
            done_d             = 1'b1;
          end else if (req_i.is_shared) begin
            res_d.status = ST_SHARED;
            done_d       = 1'b1;
          end else if (req_i.rect_width > aw || req_i.rect_height > ah) begin
            res_d.status = ST_TOO_LARGE;
            done_d       = 1'b1;
          end
        end
      end
      S_SCAN: begin
        res_d.atlas_index  = '0;
        res_d.pos_x        = '0;
        res_d.pos_y        = '0;
        res_d.atlases_used = USED_BITS'(total_q);
        if (row_hit) begin
          // Advance the left edge of the matching row
          ram_we             = 1'b1;
          ram_wdata.left     = coord_t'(ram_rdata.left + w_q);
          res_d.status       = ST_PLACED;
          res_d.atlas_index  = IDX_BITS'(ck_atlas_q);
          res_d.pos_x        = ram_rdata.left[POS_BITS-1:0];
          res_d.pos_y        = ram_rdata.top[POS_BITS-1:0];
          done_d             = 1'b1;
        end else if (open_row) begin
          // Open a row at the bottom of the chosen atlas
          ram_we         = 1'b1;
          ram_waddr      = slot_of(open_atlas, open_rows);
          ram_wdata.top  = open_top;
          ram_wdata.left = w_q;
          ram_wdata.tall = h_q;
          rows_d[open_atlas[AIW-1:0]] = RW'(open_rows + 1'b1);
          hl_d[open_atlas[AIW-1:0]]   = sat_sub(open_hl, h_q);
          if (ck_kind_q == TK_DONE) total_d = AW'(total_q + 1'b1);
          res_d.status       = ST_PLACED;
          res_d.atlas_index  = IDX_BITS'(open_atlas);
          res_d.pos_y        = open_top[POS_BITS-1:0];
          res_d.atlases_used = USED_BITS'(total_d);
          done_d             = 1'b1;
        end else if (no_room) begin
          res_d.status = ST_NO_ROOM;
          done_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_q     <= 1'b0;
      ia_q      <= '0;
      ir_q      <= '0;
      ck_kind_q <= TK_NONE;
      total_q   <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < MAX_ATLASES; i++) rows_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      run_q     <= run_d;
      ia_q      <= ia_d;
      ir_q      <= ir_d;
      ck_kind_q <= ck_kind_d;
      total_q   <= total_d;
      done_q    <= done_d;
      rows_q    <= rows_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q <= req_i.rect_width;
      h_q <= req_i.rect_height;
    end
    ck_atlas_q <= ia_q;
    ck_slot_q  <= raddr;
    hl_q       <= hl_d;
    res_q      <= res_d;
  end

  // Never more atlases open than exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= AW'(MAX_ATLASES))
    else $error("atlas count beyond limit");

  // A row or end token always refers to an open atlas
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && (ck_kind_q == TK_ROW || ck_kind_q == TK_END)) |->
      ck_atlas_q < total_q)
    else $error("token for an atlas that is not open");

  // A new batch answers next cycle with the cleared status and no atlases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.command == CMD_NEW_BATCH) |=>
      (done_o && result_o.status == ST_CLEARED && total_q == '0))
    else $error("new batch not answered");

  // A placement always leaves at least one atlas open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_PLACED) |-> total_q != '0)
    else $error("placed with no open atlas");

  // The scan ends on a result, never silently
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_IDLE) |=> done_o)
    else $error("scan ended without a result");

endmodule

@@ hdl/sap_ram.sv @@
// ----------------------------------------------------------------------------
// sap_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sap_ram #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/tb_shelf_atlas_packer.sv @@
// ----------------------------------------------------------------------------
// tb_shelf_atlas_packer
// Self-checking bench for the first-fit shelf atlas packer. A built-in shelf
// predictor tracks rows and atlases per batch and checks every result. It runs
// directed corner cases, then random batches under changing atlas sizes and
// three sender idling profiles.
// ----------------------------------------------------------------------------
module tb_shelf_atlas_packer
  import sap_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ATLASES    = 4;
  localparam int unsigned ROWS       = 16;
  localparam int unsigned SLOTS      = ATLASES * ROWS;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned SETTLE_CYC = 80;

  // Shelf predictor and store of expected placements
  class placement_checker;
    coord_t      width_reg;
    coord_t      height_reg;
    coord_t      shelf_top[SLOTS];
    coord_t      shelf_left[SLOTS];
    coord_t      shelf_tall[SLOTS];
    int unsigned shelf_count[ATLASES];
    coord_t      free_height[ATLASES];
    int unsigned open_atlases;
    sap_res_t    expected_places[$];
    int unsigned mismatches;

    function new();
      width_reg  = coord_t'(2048);
      height_reg = coord_t'(2048);
      mismatches = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      for (int i = 0; i < ATLASES; i++) begin
        shelf_count[i] = 0;
        free_height[i] = '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        shelf_top[i]  = '0;
        shelf_left[i] = '0;
        shelf_tall[i] = '0;
      end
      open_atlases = 0;
    endfunction

    // Register values above the largest atlas act as the largest atlas
    function coord_t clamp_dim(input coord_t v);
      return (v > coord_t'(4096)) ? coord_t'(4096) : v;
    endfunction

    function coord_t floor_sub(input coord_t a, input coord_t b);
      return (a > b) ? coord_t'(a - b) : coord_t'(0);
    endfunction

    function void set_regs(input coord_t w, input coord_t h);
      width_reg  = w;
      height_reg = h;
    endfunction

    // Work out the result of one accepted request and queue it
    function void predict_placement(input sap_req_t r);
      sap_res_t    res;
      coord_t      aw;
      coord_t      ah;
      int unsigned a;
      int unsigned s;
      int unsigned ai;
      int unsigned ri;
      bit          got_row;
      bit          got_atlas;
      res       = '0;
      aw        = clamp_dim(width_reg);
      ah        = clamp_dim(height_reg);
      got_row   = 1'b0;
      got_atlas = 1'b0;
      a         = 0;
      s         = 0;
      if (r.command == CMD_NEW_BATCH) begin
        clear_batch();
        res.status = ST_CLEARED;
      end else if (r.is_shared) begin
        res.status = ST_SHARED;
      end else if (r.rect_width > aw || r.rect_height > ah) begin
        res.status = ST_TOO_LARGE;
      end else begin
        // First fitting row, else the first atlas with height and a row slot left
        for (ai = 0; ai < open_atlases && !got_row && !got_atlas; ai++) begin
          a = ai;
          for (ri = 0; ri < shelf_count[ai] && !got_row; ri++) begin
            if (r.rect_width <= floor_sub(aw, shelf_left[ai*ROWS+ri]) &&
                r.rect_height <= shelf_tall[ai*ROWS+ri]) begin
              got_row = 1'b1;
              s       = ai*ROWS + ri;
            end
          end
          if (!got_row && r.rect_height <= free_height[ai] && shelf_count[ai] < ROWS)
            got_atlas = 1'b1;
        end
        // Open a fresh atlas while any are left
        if (!got_row && !got_atlas) begin
          if (open_atlases < ATLASES) begin
            a              = open_atlases;
            open_atlases++;
            shelf_count[a] = 0;
            free_height[a] = ah;
            got_atlas      = 1'b1;
          end else begin
            res.status = ST_NO_ROOM;
          end
        end
        // Open a new row at the current bottom of the atlas
        if (!got_row && got_atlas) begin
          s              = a*ROWS + shelf_count[a];
          shelf_count[a]++;
          shelf_top[s]   = floor_sub(ah, free_height[a]);
          shelf_left[s]  = '0;
          shelf_tall[s]  = r.rect_height;
          free_height[a] = floor_sub(free_height[a], r.rect_height);
          got_row        = 1'b1;
        end
        if (got_row) begin
          res.status      = ST_PLACED;
          res.atlas_index = IDX_BITS'(a);
          res.pos_x       = POS_BITS'(shelf_left[s]);
          res.pos_y       = POS_BITS'(shelf_top[s]);
          shelf_left[s]   = coord_t'(shelf_left[s] + r.rect_width);
        end
      end
      res.atlases_used = USED_BITS'(open_atlases);
      expected_places.push_back(res);
    endfunction

    // Compare one result with the oldest expectation
    function void check_placement(input sap_res_t got);
      sap_res_t exp_res;
      if (expected_places.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        mismatches++;
        return;
      end
      exp_res = expected_places.pop_front();
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, got.status);
        mismatches++;
      end
      if (got.atlas_index !== exp_res.atlas_index) begin
        $error("atlas_index: expected %0d, actual %0d", exp_res.atlas_index, got.atlas_index);
        mismatches++;
      end
      if (got.pos_x !== exp_res.pos_x) begin
        $error("pos_x: expected %0d, actual %0d", exp_res.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== exp_res.pos_y) begin
        $error("pos_y: expected %0d, actual %0d", exp_res.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.atlases_used !== exp_res.atlases_used) begin
        $error("atlases_used: expected %0d, actual %0d",
               exp_res.atlases_used, got.atlases_used);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  sap_req_t             req_i;
  logic                 done_o;
  sap_res_t             result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  coord_t               cfg_wdata_i;

  placement_checker sb;
  int unsigned      quiet_cycles;

  shelf_atlas_packer #(
    .MAX_ATLASES(ATLASES),
    .MAX_ROWS   (ROWS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Note accepted requests before checking results, so a same-cycle answer
  // still finds its expectation; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.predict_placement(req_i);
      if (done_o) sb.check_placement(result_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic sap_req_t make_req(input logic cmd, input int unsigned w,
                                        input int unsigned h, input logic shared);
    sap_req_t r;
    r.command     = cmd;
    r.rect_width  = coord_t'(w);
    r.rect_height = coord_t'(h);
    r.is_shared   = shared;
    return r;
  endfunction

  // Present one transaction and hold it until taken
  task automatic send_item(input sap_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Idle the sender for a random stretch
  task automatic sender_gap(input int unsigned pct);
    int unsigned n;
    n = 0;
    while (n < 30 && $urandom_range(99) < pct) n++;
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_places.size() != 0) @(posedge clk_i);
  endtask

  // Write both atlas registers while the block is idle
  task automatic reconfigure(input coord_t w, input coord_t h);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ATLAS_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ATLAS_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_regs(w, h);
  endtask

  function automatic coord_t pick_dim();
    case ($urandom_range(9))
      0:       return coord_t'(1);
      1:       return coord_t'($urandom_range(2, 16));
      2, 3:    return coord_t'($urandom_range(17, 600));
      4:       return coord_t'(2048);
      5:       return coord_t'(4096);
      6:       return coord_t'($urandom_range(4097, 8191));
      7:       return coord_t'($urandom_range(0, 8191));
      8:       return coord_t'($urandom_range(600, 4096));
      default: return coord_t'($urandom_range(0, 1));
    endcase
  endfunction

  // Mostly fitting rectangles with few distinct heights, plus noise
  function automatic sap_req_t random_item();
    int unsigned aw;
    int unsigned ah;
    int unsigned sel;
    int unsigned w;
    int unsigned h;
    aw  = 32'(sb.clamp_dim(sb.width_reg));
    ah  = 32'(sb.clamp_dim(sb.height_reg));
    sel = $urandom_range(99);
    if (sel < 4)
      return make_req(CMD_NEW_BATCH, $urandom_range(8191), $urandom_range(8191),
                      1'($urandom_range(1)));
    if (sel < 10)
      return make_req(CMD_PLACE, $urandom_range(8191), $urandom_range(8191), 1'b1);
    if (sel < 18)
      return make_req(CMD_PLACE, $urandom_range(8191), $urandom_range(8191), 1'b0);
    w = $urandom_range(1) ? $urandom_range(0, aw / 4) : $urandom_range(0, aw);
    case ($urandom_range(3))
      0:       h = $urandom_range(0, 3);
      1:       h = $urandom_range(0, ah / 8);
      2:       h = $urandom_range(0, ah / 3);
      default: h = $urandom_range(0, ah);
    endcase
    if (h > ah) h = ah;
    return make_req(CMD_PLACE, w, h, 1'b0);
  endfunction

  initial begin
    sb           = new();
    quiet_cycles = 0;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_ATLAS_WIDTH;
    cfg_wdata_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: zero-sized item, shared and oversize checks, a full atlas
    send_item(make_req(CMD_PLACE, 0, 0, 1'b0));
    sender_gap(22);
    send_item(make_req(CMD_PLACE, 8191, 8191, 1'b1));
    send_item(make_req(CMD_PLACE, 8191, 1, 1'b0));
    sender_gap(22);
    send_item(make_req(CMD_PLACE, 1, 8191, 1'b0));
    send_item(make_req(CMD_PLACE, 2049, 10, 1'b0));
    send_item(make_req(CMD_PLACE, 2048, 2048, 1'b0));
    sender_gap(22);
    send_item(make_req(CMD_PLACE, 100, 1, 1'b0));
    send_item(make_req(CMD_NEW_BATCH, 8191, 8191, 1'b1));
    send_item(make_req(CMD_PLACE, 2048, 1, 1'b0));

    // Registers above range, zero-sized rectangle at the far edge
    reconfigure(coord_t'(8191), coord_t'(4096));
    send_item(make_req(CMD_NEW_BATCH, 0, 0, 1'b0));
    send_item(make_req(CMD_PLACE, 4096, 0, 1'b0));
    send_item(make_req(CMD_PLACE, 0, 0, 1'b0));
    send_item(make_req(CMD_PLACE, 1, 4096, 1'b0));
    send_item(make_req(CMD_PLACE, 0, 0, 1'b0));

    // Shrink to nothing mid-batch
    reconfigure(coord_t'(0), coord_t'(0));
    send_item(make_req(CMD_PLACE, 0, 0, 1'b0));
    send_item(make_req(CMD_PLACE, 1, 0, 1'b0));

    // Tiny atlases run out: atlas limit
    reconfigure(coord_t'(1), coord_t'(1));
    send_item(make_req(CMD_NEW_BATCH, 0, 0, 1'b0));
    repeat (5) send_item(make_req(CMD_PLACE, 1, 1, 1'b0));

    // Random batches: sender idles 22%, then 76%, then never
    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 4; blk++) begin
        reconfigure(pick_dim(), pick_dim());
        if ($urandom_range(1)) send_item(make_req(CMD_NEW_BATCH, 0, 0, 1'b0));
        for (int k = 0; k < 34; k++) begin
          sender_gap((ph == 0) ? 22 : (ph == 1) ? 76 : 0);
          if ($urandom_range(39) == 0) drain();
          send_item(random_item());
        end
      end
    end

    // Let the last results arrive, then settle
    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_places.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
